FILE: hw/rtl/tpsw_pkg.sv
// ----------------------------------------------------------------------------
// TMDS palette serial word encoder package
// Payload types, control symbols and the per-channel encode functions.
// ----------------------------------------------------------------------------
package tpsw_pkg;

    localparam int SYM_W  = 10;
    localparam int WORD_W = 62;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Fixed control symbols
    localparam logic [SYM_W-1:0] SYM_C0 = 10'b1101010100;
    localparam logic [SYM_W-1:0] SYM_C1 = 10'b0010101011;
    localparam logic [SYM_W-1:0] SYM_C2 = 10'b0101010100;
    localparam logic [SYM_W-1:0] SYM_C3 = 10'b1010101011;

    // Groups of symbol bits 7..0 plus the gap flip in the alternate word
    localparam logic [WORD_W-1:0] ALT_MASK = 62'h0003_ffff_ffff_ffff;

    localparam logic [1:0] PAIR_ONE  = 2'b01;
    localparam logic [1:0] PAIR_ZERO = 2'b10;
    localparam logic [1:0] PAIR_FLIP = 2'b11;

    typedef enum logic [1:0] {
        REG_INVERT_PAIRS   = 2'd0,
        REG_RGB_ORDER      = 2'd1,
        REG_SWAP_RED_GREEN = 2'd2
    } reg_index_t;

    typedef enum logic [0:0] {
        CMD_COLOR = 1'b0,
        CMD_SYNC  = 1'b1
    } command_t;

    typedef struct packed {
        logic        command;
        logic [23:0] color;
        logic [1:0]  sync_code;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_primary;
        logic [WORD_W-1:0] word_alternate;
    } result_t;

    // Transition-minimize one byte, no running disparity
    function automatic logic [SYM_W-1:0] tmds_min(input logic [7:0] d);
        logic [3:0]       ones;
        logic             xn;
        logic [SYM_W-1:0] q;
        ones = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            ones = ones + {3'd0, d[i]};
        end
        xn = (ones > 4'd4) || ((ones == 4'd4) && !d[0]);
        q = '0;
        q[0] = d[0];
        for (int i = 1; i < 8; i++)
        begin
            q[i] = q[i-1] ^ d[i] ^ xn;
        end
        q[9] = xn;
        q[8] = !xn;
        return q;
    endfunction

    function automatic logic [1:0] pair_of(input logic b, input logic inv);
        logic [1:0] p;
        p = b ? PAIR_ONE : PAIR_ZERO;
        if (inv)
        begin
            p = p ^ PAIR_FLIP;
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/tmds_palette_serial_word_encoder_top.sv
// ----------------------------------------------------------------------------
// TMDS palette serial word encoder
// An accepted transfer passes the input register, then the result register, before the done strobe.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Timing is set by the input register and the result register around one
// short stage of encode and pair-packing logic.
// Reset clears the valid flags and restores invert_pairs=0, rgb_order=1,
// swap_red_green=0.
// ----------------------------------------------------------------------------
module tmds_palette_serial_word_encoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tpsw_pkg::item_t                 item,
    output logic                            done,
    output tpsw_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tpsw_pkg::ADDR_W-1:0]     paddr,
    input  logic [tpsw_pkg::DATA_W-1:0]     pwdata,
    output logic [tpsw_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import tpsw_pkg::*;

    logic       invert_pairs_reg;
    logic       rgb_order_reg;
    logic       swap_red_green_reg;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       done_reg;
    result_t    result_reg;
    result_t    result_next;
    reg_index_t reg_sel;
    logic       cfg_write;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign done   = done_reg;
    assign result = result_reg;

    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_pairs_reg   <= 1'b0;
            rgb_order_reg      <= 1'b1;
            swap_red_green_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_INVERT_PAIRS:   invert_pairs_reg   <= pwdata[0];
                REG_RGB_ORDER:      rgb_order_reg      <= pwdata[0];
                REG_SWAP_RED_GREEN: swap_red_green_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_INVERT_PAIRS:   prdata[0] = invert_pairs_reg;
            REG_RGB_ORDER:      prdata[0] = rgb_order_reg;
            REG_SWAP_RED_GREEN: prdata[0] = swap_red_green_reg;
            default:            prdata = '0;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_item_reg <= item;
        end
    end

    // Encode and pack
    always_comb
    begin
        logic [SYM_W-1:0]  sym_r;
        logic [SYM_W-1:0]  sym_g;
        logic [SYM_W-1:0]  sym_b;
        logic [SYM_W-1:0]  ser_r;
        logic [SYM_W-1:0]  ser_g;
        logic [5:0]        grp;
        logic [WORD_W-1:0] word;

        if (in_item_reg.command == CMD_SYNC)
        begin
            sym_r = SYM_C0;
            sym_g = SYM_C0;
            case (in_item_reg.sync_code)
                2'd0:    sym_b = SYM_C3;
                2'd1:    sym_b = SYM_C2;
                2'd2:    sym_b = SYM_C1;
                default: sym_b = SYM_C0;
            endcase
        end
        else
        begin
            sym_r = tmds_min(in_item_reg.color[23:16]);
            sym_g = tmds_min(in_item_reg.color[15:8]);
            sym_b = tmds_min(in_item_reg.color[7:0]);
        end

        ser_r = swap_red_green_reg ? sym_g : sym_r;
        ser_g = swap_red_green_reg ? sym_r : sym_g;

        word = '0;
        for (int k = 0; k < SYM_W; k++)
        begin
            if (rgb_order_reg)
            begin
                grp = {pair_of(ser_r[k], invert_pairs_reg),
                       pair_of(ser_g[k], invert_pairs_reg),
                       pair_of(sym_b[k], invert_pairs_reg)};
            end
            else
            begin
                grp = {pair_of(sym_b[k], invert_pairs_reg),
                       pair_of(ser_g[k], invert_pairs_reg),
                       pair_of(ser_r[k], invert_pairs_reg)};
            end
            // Upper five groups sit above the 2-bit gap
            if (k >= 5)
            begin
                word[k*6+2 +: 6] = grp;
            end
            else
            begin
                word[k*6 +: 6] = grp;
            end
        end

        result_next.word_primary = word;
        if (in_item_reg.command == CMD_SYNC)
        begin
            result_next.word_alternate = word;
        end
        else
        begin
            result_next.word_alternate = word ^ ALT_MASK;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> in_valid_reg)
        else $error("accepted transfer did not reach the input register");

    a_done_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("done strobe without a staged item");

    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.word_primary[31:30] == 2'b00))
        else $error("gap bits set in primary word");

    a_alt_relation: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.word_alternate == result.word_primary)
              || ((result.word_alternate ^ result.word_primary) == ALT_MASK)))
        else $error("alternate word does not match primary");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TMDS palette serial word encoder testbench
// Sends colors and sync codes through the start/busy port under all register
// settings. A local model predicts both serializer words for each transfer,
// and every done strobe is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import tpsw_pkg::*;

    localparam int  CLK_HALF      = 10;
    localparam int  RESET_CYCLES  = 5;
    localparam int  DRAIN_CYCLES  = 6;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RANDOM_ITEMS  = 1800;
    localparam int  IDLE_PERCENT  = 24;
    localparam int  SYNC_PERCENT  = 20;

    // Register slot past the last one; writes there must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [1:0] LINE_ONE  = 2'b01;
    localparam logic [1:0] LINE_ZERO = 2'b10;

    localparam logic [9:0] CTRL_SYM_0 = 10'b1101010100;
    localparam logic [9:0] CTRL_SYM_1 = 10'b0010101011;
    localparam logic [9:0] CTRL_SYM_2 = 10'b0101010100;
    localparam logic [9:0] CTRL_SYM_3 = 10'b1010101011;

    localparam logic [61:0] LOW_GROUPS_MASK = 62'h0003_ffff_ffff_ffff;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    item_t               item;
    logic                done;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Register copies kept by the predictor
    logic cfg_invert;
    logic cfg_rgb_order;
    logic cfg_swap_rg;

    result_t pending_words[$];
    int      errors;
    int      cycles;
    bit      idle_on;

    tmds_palette_serial_word_encoder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [9:0] minimize_byte(input logic [7:0] d);
        int         ones;
        logic       use_xnor;
        logic [9:0] q;
        ones = $countones(d);
        use_xnor = (ones > 4) || ((ones == 4) && !d[0]);
        q = '0;
        q[0] = d[0];
        for (int i = 1; i < 8; i++)
        begin
            q[i] = q[i-1] ^ d[i] ^ use_xnor;
        end
        q[9] = use_xnor;
        q[8] = !use_xnor;
        return q;
    endfunction

    function automatic logic [1:0] line_pair(input logic b);
        logic [1:0] p;
        p = b ? LINE_ONE : LINE_ZERO;
        if (cfg_invert)
        begin
            p = ~p;
        end
        return p;
    endfunction

    function automatic logic [61:0] pack_word(input logic [9:0] sr, input logic [9:0] sg,
                                              input logic [9:0] sb);
        logic [9:0]  r;
        logic [9:0]  g;
        logic [5:0]  group;
        logic [61:0] w;
        r = cfg_swap_rg ? sg : sr;
        g = cfg_swap_rg ? sr : sg;
        w = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (cfg_rgb_order)
            begin
                group = {line_pair(r[9-i]), line_pair(g[9-i]), line_pair(sb[9-i])};
            end
            else
            begin
                group = {line_pair(sb[9-i]), line_pair(g[9-i]), line_pair(r[9-i])};
            end
            w = w << 6;
            // leave the two-bit gap after the fifth group
            if (i == 5)
            begin
                w = w << 2;
            end
            w = w | {56'd0, group};
        end
        return w;
    endfunction

    function automatic logic [9:0] blue_control(input logic [1:0] code);
        case (code)
            2'd0:    return CTRL_SYM_3;
            2'd1:    return CTRL_SYM_2;
            2'd2:    return CTRL_SYM_1;
            default: return CTRL_SYM_0;
        endcase
    endfunction

    function automatic result_t predict_words(input item_t it);
        result_t r;
        if (it.command == CMD_SYNC)
        begin
            r.word_primary   = pack_word(CTRL_SYM_0, CTRL_SYM_0, blue_control(it.sync_code));
            r.word_alternate = r.word_primary;
        end
        else
        begin
            r.word_primary   = pack_word(minimize_byte(it.color[23:16]),
                                         minimize_byte(it.color[15:8]),
                                         minimize_byte(it.color[7:0]));
            r.word_alternate = r.word_primary ^ LOW_GROUPS_MASK;
        end
        return r;
    endfunction

    // Send one item, with an optional random gap ahead of it
    task automatic send_item(input item_t it);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT))
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_words.push_back(predict_words(it));
    endtask

    task automatic send_color(input logic [23:0] c);
        item_t it;
        it.command   = CMD_COLOR;
        it.color     = c;
        it.sync_code = 2'($urandom);
        send_item(it);
    endtask

    task automatic send_sync(input logic [1:0] code);
        item_t it;
        it.command   = CMD_SYNC;
        it.color     = 24'($urandom);
        it.sync_code = code;
        send_item(it);
    endtask

    task automatic send_random;
        item_t it;
        it.command   = ($urandom_range(99) < SYNC_PERCENT) ? CMD_SYNC : CMD_COLOR;
        it.color     = 24'($urandom);
        it.sync_code = 2'($urandom);
        send_item(it);
    endtask

    // Drop start and wait for every outstanding result
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic value);
        logic [DATA_W-1:0] data;
        data    = $urandom;
        data[0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_INVERT_PAIRS:   cfg_invert    = value;
            REG_RGB_ORDER:      cfg_rgb_order = value;
            REG_SWAP_RED_GREEN: cfg_swap_rg   = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Extremes of the color field, the popcount tie cases and every sync code
    task automatic test_reset_defaults;
        idle_on = 1'b1;
        send_color(24'h000000);
        send_color(24'hffffff);
        send_color({8'h0f, 8'h1e, 8'h1f});
        send_color({8'h07, 8'hf0, 8'he1});
        send_color(24'h55aa80);
        send_color(24'h01fe0f);
        send_color(24'h1e1e1e);
        send_color(24'h0f0f0f);
        send_color(24'h800001);
        send_color(24'h123456);
        send_color(24'hedcba9);
        for (int c = 0; c < 4; c++)
        begin
            send_sync(2'(c));
        end
        send_sync(2'd0);
        send_color(24'h7f3c81);
        drain;
    endtask

    task automatic test_ignored_register;
        write_register(REG_UNUSED, 1'b1);
        idle_on = 1'b1;
        for (int n = 0; n < 12; n++)
        begin
            send_random;
        end
        send_color(24'h1e0f1f);
        drain;
    endtask

    // Walk all eight register settings with random traffic under each
    task automatic test_register_sweep;
        logic [2:0] setting;
        for (int s = 0; s < 8; s++)
        begin
            setting = 3'(s);
            write_register(REG_INVERT_PAIRS, setting[0]);
            write_register(REG_RGB_ORDER, setting[1]);
            write_register(REG_SWAP_RED_GREEN, setting[2]);
            // one setting runs back to back with no gaps at all
            idle_on = (s != 3);
            send_color(24'h000000);
            send_color(24'hffffff);
            send_sync(2'(s));
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
            begin
                send_random;
            end
            drain;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (result.word_primary !== want.word_primary)
                begin
                    $display("%0t: word_primary expected %h actual %h", $time,
                             want.word_primary, result.word_primary);
                    errors++;
                end
                if (result.word_alternate !== want.word_alternate)
                begin
                    $display("%0t: word_alternate expected %h actual %h", $time,
                             want.word_alternate, result.word_alternate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_invert    = 1'b0;
        cfg_rgb_order = 1'b1;
        cfg_swap_rg   = 1'b0;
        errors        = 0;
        cycles        = 0;
        idle_on       = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults;
        test_ignored_register;
        test_register_sweep;

        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
